// ===== rtl/kmhq_pkg.sv =====
`default_nettype none
package kmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 8;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEYS     = 1 << KEY_W;

  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_GET    = 3'd3;
  localparam logic [2:0] CMD_SET    = 3'd4;
  localparam logic [2:0] CMD_PEEK   = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_POS_WAIT, S_REM_RD, S_REM_GONE, S_REM_LAST,
    S_UP_RD, S_UP_EV, S_DN_RD_L, S_DN_RD_R, S_DN_EV, S_POST, S_INS, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RD_IDX, RD_LAST, RD_PARENT, RD_LEFT, RD_RIGHT
  } rd_sel_t;

  typedef struct packed {
    logic       ld_in;
    logic       set_idx_zero;
    logic       set_idx_pos;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       latch_gone;
    logic       rem_commit;
    logic       ld_cur_rd;
    logic       ins;
    logic       wr_final;
    logic       up_step;
    logic       dn_step;
    logic       latch_left;
    logic       out_load;
    logic [2:0] out_status;
    logic       out_show;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       present;
    logic       empty;
    logic       full;
    logic       idx_zero;
    logic       idx_lt_last;
    logic       l_in;
    logic       up_move;
    logic       dn_move;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/kmhq_dp.sv =====
`default_nettype none
module kmhq_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire kmhq_pkg::dp_cmd_t       cmd,
  output kmhq_pkg::dp_stat_t           stat,
  input  wire logic [2:0]              in_command,
  input  wire logic [kmhq_pkg::KEY_W-1:0] in_key,
  input  wire logic signed [kmhq_pkg::VAL_W-1:0] in_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   out_status,
  output logic [kmhq_pkg::KEY_W-1:0]   out_key,
  output logic signed [kmhq_pkg::VAL_W-1:0] out_value,
  output logic [kmhq_pkg::CNT_W-1:0]   out_entry_count
);
  import kmhq_pkg::*;

  logic [KEY_W-1:0] heap_key_mem [CAPACITY];
  logic [VAL_W-1:0] heap_val_mem [CAPACITY];
  logic [IDX_W-1:0] pos_mem      [KEYS];
  logic [KEYS-1:0]  valid_r;

  logic [2:0]        cmd_r;
  logic [KEY_W-1:0]  key_r, cur_key_r, gone_key_r, lkey_r, hrd_key_r;
  logic [VAL_W-1:0]  val_r, cur_val_r, gone_val_r, lval_r, hrd_val_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt, prd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [2:0]        ost_r;
  logic [KEY_W-1:0]  okey_r;
  logic [VAL_W-1:0]  oval_r;
  logic [CNT_W-1:0]  ocnt_r;

  logic [IDX_W-1:0]  rd_addr, wr_addr, parent_idx;
  logic [CNT_W-1:0]  l_idx, last_idx;
  logic [CNT_W:0]    r_idx;
  logic              wr_en, a_gt, b_gt, pick_right;
  logic [KEY_W-1:0]  wr_key;
  logic [VAL_W-1:0]  wr_val;

  assign parent_idx = (idx_r - IDX_W'(1)) >> 1;
  assign l_idx      = {idx_r, 1'b1};
  assign r_idx      = {1'b0, idx_r, 1'b0} + (CNT_W+1)'(2);
  assign last_idx   = cnt_r - CNT_W'(1);

  // The left child sits in lval_r, the right child in the read register.
  assign a_gt = $signed(cur_val_r) < $signed(lval_r);
  assign b_gt = (r_idx < {1'b0, cnt_r}) && ($signed(cur_val_r) < $signed(hrd_val_r));
  assign pick_right = (a_gt && b_gt) ? ($signed(lval_r) < $signed(hrd_val_r)) : b_gt;

  always_comb begin
    stat.cmd         = cmd_r;
    stat.present     = valid_r[key_r];
    stat.empty       = (cnt_r == '0);
    stat.full        = (cnt_r == CNT_W'(CAPACITY));
    stat.idx_zero    = (idx_r == '0);
    stat.idx_lt_last = ({1'b0, idx_r} < last_idx);
    stat.l_in        = (l_idx < cnt_r);
    stat.up_move     = $signed(hrd_val_r) < $signed(cur_val_r);
    stat.dn_move     = a_gt || b_gt;
    stat.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX:    rd_addr = idx_r;
      RD_LAST:   rd_addr = last_idx[IDX_W-1:0];
      RD_PARENT: rd_addr = parent_idx;
      RD_LEFT:   rd_addr = l_idx[IDX_W-1:0];
      RD_RIGHT:  rd_addr = r_idx[IDX_W-1:0];
      default:   rd_addr = idx_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_key  = cur_key_r;
    wr_val  = cur_val_r;
    idx_nxt = idx_r;
    if (cmd.wr_final) begin
      wr_en = 1'b1;
    end else if (cmd.up_step && stat.up_move) begin
      wr_en   = 1'b1;
      wr_key  = hrd_key_r;
      wr_val  = hrd_val_r;
      idx_nxt = parent_idx;
    end else if (cmd.dn_step) begin
      wr_en = 1'b1;
      if (stat.dn_move) begin
        wr_key  = pick_right ? hrd_key_r : lkey_r;
        wr_val  = pick_right ? hrd_val_r : lval_r;
        idx_nxt = pick_right ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
      end
    end
    if (cmd.set_idx_zero) idx_nxt = '0;
    if (cmd.set_idx_pos)  idx_nxt = prd_r;
    if (cmd.ins)          idx_nxt = cnt_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_key_mem[wr_addr] <= wr_key;
      heap_val_mem[wr_addr] <= wr_val;
      pos_mem[wr_key]       <= wr_addr;
    end
    if (cmd.rd_en) begin
      hrd_key_r <= heap_key_mem[rd_addr];
      hrd_val_r <= heap_val_mem[rd_addr];
    end
    prd_r <= pos_mem[key_r];
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.ld_in) begin
      cmd_r <= in_command;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd.latch_gone) begin
      gone_key_r <= hrd_key_r;
      gone_val_r <= hrd_val_r;
    end
    if (cmd.latch_left) begin
      lkey_r <= hrd_key_r;
      lval_r <= hrd_val_r;
    end
    if (cmd.ld_cur_rd) begin
      cur_key_r <= hrd_key_r;
      cur_val_r <= hrd_val_r;
    end else if (cmd.ins) begin
      cur_key_r <= key_r;
      cur_val_r <= val_r;
    end
    if (cmd.out_load) begin
      ost_r  <= cmd.out_status;
      okey_r <= cmd.out_show ? gone_key_r : '0;
      if (cmd.out_show) begin
        oval_r <= gone_val_r;
      end else if (cmd.out_status == ST_EMPTY || cmd.out_status == ST_NOT_FOUND) begin
        oval_r <= '1;
      end else begin
        oval_r <= '0;
      end
      ocnt_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.rem_commit) begin
        valid_r[hrd_key_r] <= 1'b0;
        cnt_r              <= last_idx;
      end else if (cmd.ins) begin
        valid_r[key_r] <= 1'b1;
        cnt_r          <= cnt_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = ost_r;
  assign out_key         = okey_r;
  assign out_value       = oval_r;
  assign out_entry_count = ocnt_r;

endmodule
`default_nettype wire

// ===== rtl/kmhq_ctrl.sv =====
`default_nettype none
module kmhq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire kmhq_pkg::dp_stat_t stat,
  output kmhq_pkg::dp_cmd_t       cmd
);
  import kmhq_pkg::*;

  state_t     state_r, state_nxt;
  logic       first_r, first_nxt;
  logic       ins_done_r, ins_done_nxt;
  logic [2:0] st_r, st_nxt;
  logic       show_r, show_nxt;
  logic       reads_only;

  assign reads_only = (stat.cmd == CMD_GET) || (stat.cmd == CMD_PEEK);

  always_comb begin
    state_nxt    = state_r;
    first_nxt    = first_r;
    ins_done_nxt = ins_done_r;
    st_nxt       = st_r;
    show_nxt     = show_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt    = S_DISPATCH;
          ins_done_nxt = 1'b0;
          st_nxt       = ST_OK;
          show_nxt     = 1'b0;
        end
      end
      S_DISPATCH: begin
        priority case (stat.cmd)
          CMD_PUSH: begin
            if (stat.present) begin
              st_nxt = ST_DUPLICATE;
              state_nxt = S_FINISH;
            end else if (stat.full) begin
              st_nxt = ST_FULL;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_INS;
            end
          end
          CMD_POP, CMD_PEEK: begin
            if (stat.empty) begin
              st_nxt = ST_EMPTY;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_REM_RD;
            end
          end
          CMD_REMOVE, CMD_GET, CMD_SET: begin
            if (!stat.present) begin
              st_nxt = ST_NOT_FOUND;
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_POS_WAIT;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_POS_WAIT: state_nxt = S_REM_RD;
      S_REM_RD:   state_nxt = S_REM_GONE;
      S_REM_GONE: begin
        show_nxt = 1'b1;
        if (reads_only) begin
          state_nxt = S_FINISH;
        end else if (stat.idx_lt_last) begin
          state_nxt = S_REM_LAST;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_REM_LAST: begin
        first_nxt = 1'b1;
        state_nxt = stat.idx_zero ? S_DN_RD_L : S_UP_RD;
      end
      S_UP_RD: state_nxt = stat.idx_zero ? S_POST : S_UP_EV;
      S_UP_EV: begin
        first_nxt = 1'b0;
        if (stat.up_move) begin
          state_nxt = S_UP_RD;
        end else if (first_r) begin
          state_nxt = S_DN_RD_L;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_DN_RD_L: state_nxt = stat.l_in ? S_DN_RD_R : S_POST;
      S_DN_RD_R: state_nxt = S_DN_EV;
      S_DN_EV:   state_nxt = stat.dn_move ? S_DN_RD_L : S_POST;
      S_POST: begin
        state_nxt = (stat.cmd == CMD_SET && !ins_done_r) ? S_INS : S_FINISH;
      end
      S_INS: begin
        ins_done_nxt = 1'b1;
        first_nxt    = 1'b0;
        state_nxt    = S_UP_RD;
      end
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_IDX;
    cmd.out_status = st_r;
    cmd.out_show   = show_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
      end
      S_DISPATCH: cmd.set_idx_zero = 1'b1;
      S_POS_WAIT: cmd.set_idx_pos = 1'b1;
      S_REM_RD:   cmd.rd_en = 1'b1;
      S_REM_GONE: begin
        cmd.latch_gone = 1'b1;
        cmd.rem_commit = !reads_only;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_LAST;
      end
      S_REM_LAST: cmd.ld_cur_rd = 1'b1;
      S_UP_RD: begin
        cmd.wr_final = stat.idx_zero;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_PARENT;
      end
      S_UP_EV: begin
        cmd.up_step  = 1'b1;
        cmd.wr_final = !stat.up_move && !first_r;
      end
      S_DN_RD_L: begin
        cmd.wr_final = !stat.l_in;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_LEFT;
      end
      S_DN_RD_R: begin
        cmd.latch_left = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_RIGHT;
      end
      S_DN_EV:  cmd.dn_step = 1'b1;
      S_POST:   cmd.rd_en = 1'b0;
      S_INS:    cmd.ins = 1'b1;
      S_FINISH: cmd.out_load = stat.out_free;
      default:  cmd.rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      first_r    <= 1'b0;
      ins_done_r <= 1'b0;
      st_r       <= ST_OK;
      show_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      first_r    <= first_nxt;
      ins_done_r <= ins_done_nxt;
      st_r       <= st_nxt;
      show_r     <= show_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/keyed_max_heap_queue.sv =====
`default_nettype none
// Keyed max-heap priority queue of up to 64 (key, value) entries, ordered by
// signed value with the largest on top, plus a key-to-slot table so that any
// entry can be read or removed by key. One command is handled at a time and
// each gives exactly one result beat. A set removes and then pushes. Moves
// up and down the heap are bounded by the single read port of the heap
// memory. A finished result waits in an output register, so the next command
// can start while it is still unread. A command only stalls in its last
// cycle, and only while the previous result is still waiting.
module keyed_max_heap_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 in_command,
  input  wire logic [kmhq_pkg::KEY_W-1:0] in_key,
  input  wire logic signed [kmhq_pkg::VAL_W-1:0] in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      out_status,
  output logic [kmhq_pkg::KEY_W-1:0]      out_key,
  output logic signed [kmhq_pkg::VAL_W-1:0] out_value,
  output logic [kmhq_pkg::CNT_W-1:0]      out_entry_count
);
  import kmhq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kmhq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kmhq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_value       (out_value),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire

// ===== verif/keyed_max_heap_queue_tb.sv =====
`default_nettype none
module keyed_max_heap_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmhq_pkg::*;

  typedef struct {
    logic [2:0]       status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] entry_count;
  } heap_result_t;

  // Software copy of the indexed heap that predicts each result beat.
  class heap_scoreboard;
    logic [KEY_W-1:0] slot_key[CAPACITY];
    logic signed [VAL_W-1:0] slot_val[CAPACITY];
    int key_slot[KEYS];
    bit key_held[KEYS];
    int entries;
    heap_result_t pending[$];
    int errors;

    function new();
      entries = 0;
      errors = 0;
      foreach (key_held[k]) key_held[k] = 0;
    endfunction

    function bit below(int a, int b);
      return slot_val[a] < slot_val[b];
    endfunction

    function void swap(int a, int b);
      logic [KEY_W-1:0] tk;
      logic signed [VAL_W-1:0] tv;
      tk = slot_key[a]; tv = slot_val[a];
      slot_key[a] = slot_key[b]; slot_val[a] = slot_val[b];
      slot_key[b] = tk; slot_val[b] = tv;
      key_slot[slot_key[a]] = a;
      key_slot[slot_key[b]] = b;
    endfunction

    function void climb(int i);
      while (i > 0 && below((i - 1) / 2, i)) begin
        swap(i, (i - 1) / 2);
        i = (i - 1) / 2;
      end
    endfunction

    function void descend(int i);
      int l, r, c;
      bit a, b;
      forever begin
        l = 2 * i + 1;
        r = 2 * i + 2;
        a = l < entries && below(i, l);
        b = r < entries && below(i, r);
        if (a && b) c = below(l, r) ? r : l;
        else if (a) c = l;
        else if (b) c = r;
        else break;
        swap(i, c);
        i = c;
      end
    endfunction

    function void take_out(int i, output logic [KEY_W-1:0] k,
                           output logic [VAL_W-1:0] v);
      k = slot_key[i];
      v = slot_val[i];
      if (i < entries - 1) begin
        slot_key[i] = slot_key[entries - 1];
        slot_val[i] = slot_val[entries - 1];
        key_slot[slot_key[i]] = i;
      end
      entries--;
      key_held[k] = 0;
      if (i < entries) begin
        if (i > 0 && below((i - 1) / 2, i)) climb(i);
        else descend(i);
      end
    endfunction

    function void put_in(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      slot_key[entries] = k;
      slot_val[entries] = v;
      key_slot[k] = entries;
      key_held[k] = 1;
      entries++;
      climb(entries - 1);
    endfunction

    function void note_command(logic [2:0] cmd, logic [KEY_W-1:0] k,
                               logic [VAL_W-1:0] v);
      heap_result_t r;
      bit present;
      present = key_held[k] && key_slot[k] < entries;
      r.status = ST_OK;
      r.key = '0;
      r.value = '0;
      case (cmd)
        CMD_PUSH: begin
          if (present) r.status = ST_DUPLICATE;
          else if (entries >= CAPACITY) r.status = ST_FULL;
          else put_in(k, v);
        end
        CMD_POP, CMD_PEEK: begin
          if (entries == 0) begin
            r.status = ST_EMPTY;
            r.value = '1;
          end else if (cmd == CMD_POP) begin
            take_out(0, r.key, r.value);
          end else begin
            r.key = slot_key[0];
            r.value = slot_val[0];
          end
        end
        CMD_REMOVE, CMD_GET, CMD_SET: begin
          if (!present) begin
            r.status = ST_NOT_FOUND;
            r.value = '1;
          end else if (cmd == CMD_GET) begin
            r.key = slot_key[key_slot[k]];
            r.value = slot_val[key_slot[k]];
          end else begin
            take_out(key_slot[k], r.key, r.value);
            if (cmd == CMD_SET) put_in(k, v);
          end
        end
        default: ;
      endcase
      r.entry_count = CNT_W'(entries);
      pending.insert(pending.size(), r);
    endfunction

    function void check_beat(heap_result_t got);
      heap_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.key !== e.key) begin
        $error("out_key: expected %0d, got %0d", e.key, got.key);
        errors++;
      end
      if (got.value !== e.value) begin
        $error("out_value: expected %h, got %h", e.value, got.value);
        errors++;
      end
      if (got.entry_count !== e.entry_count) begin
        $error("out_entry_count: expected %0d, got %0d", e.entry_count,
               got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_command = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] out_status;
  logic [KEY_W-1:0] out_key;
  logic signed [VAL_W-1:0] out_value;
  logic [CNT_W-1:0] out_entry_count;

  heap_scoreboard board = new();
  longint cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  keyed_max_heap_queue i_dut (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Valid drops only ahead of a gap, so a back-to-back beat keeps it high.
  task automatic send(logic [2:0] cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_key <= k;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_command(cmd, k, v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  // Result side: random back-pressure, checked at every accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_beat('{out_status, out_key, out_value, out_entry_count});
    if (!rst_n) out_ready <= 0;
    else if ($urandom_range(0, 99) < 8) out_ready <= 0;
    else if (!out_ready) out_ready <= ($urandom_range(0, 3) == 0);
    else out_ready <= 1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("keyed_max_heap_queue_tb: errors");
      $finish;
    end
  end

  initial begin
    int n;
    logic [KEY_W-1:0] pool;
    logic [2:0] cmd;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: empty cases, extremes, duplicates, unknown commands.
    send(CMD_POP, 8'd0, '0);
    send(CMD_PEEK, 8'd0, '0);
    send(CMD_GET, 8'd7, '0);
    send(CMD_REMOVE, 8'd7, '0);
    send(CMD_SET, 8'd7, '0);
    send(CMD_PUSH, 8'd0, 32'h8000_0000);
    send(CMD_PUSH, 8'd255, 32'h7fff_ffff);
    send(CMD_PUSH, 8'd255, 32'd1);
    send(CMD_PUSH, 8'd10, 32'd5);
    send(CMD_PUSH, 8'd11, 32'd5);
    send(CMD_PEEK, 8'd0, '0);
    send(CMD_GET, 8'd10, '0);
    send(CMD_SET, 8'd0, 32'd100);
    send(CMD_REMOVE, 8'd255, '0);
    send(3'd6, 8'd1, 32'd1);
    send(3'd7, 8'd2, 32'd2);
    send(CMD_POP, 8'd0, '0);
    // Fill to capacity, then hit the full case and the duplicate case.
    for (int i = 0; i < CAPACITY; i++) send(CMD_PUSH, 8'(i + 100), rand_value());
    send(CMD_PUSH, 8'd50, '0);
    send(CMD_PUSH, 8'd100, '0);
    // Back off until every result has come.
    drain();
    for (int i = 0; i < CAPACITY + 2; i++) send(CMD_POP, 8'd0, '0);
    // Random part: keys mostly from a small pool so lookups hit.
    n = 0;
    while (n < 550) begin
      pool = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 47)) : 8'($urandom());
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: cmd = CMD_PUSH;
        7, 8, 9: cmd = CMD_POP;
        10, 11: cmd = CMD_REMOVE;
        12, 13: cmd = CMD_GET;
        14, 15, 16: cmd = CMD_SET;
        17, 18: cmd = CMD_PEEK;
        default: cmd = 3'($urandom_range(6, 7));
      endcase
      send(cmd, pool, rand_value());
      n++;
      if (n == 275) drain();
    end
    drain();
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("keyed_max_heap_queue_tb: clean");
    else
      $display("keyed_max_heap_queue_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
